/* rtl/core/water_column_wave_step_macros.svh */
// assertion macros shared by the water column wave step rtl
`ifndef WATER_COLUMN_WAVE_STEP_MACROS_SVH
`define WATER_COLUMN_WAVE_STEP_MACROS_SVH

// same-cycle implication, checked outside reset
`define WCW_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define WCW_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/wcw_pkg.sv */
// shared constants and types of the water column wave step
package wcw_pkg;

  localparam int COLUMNS     = 16;
  localparam int ROWS        = 16;
  localparam int MAX_RESULTS = 16;

  localparam int IDX_W   = $clog2(COLUMNS);
  localparam int IDX1_W  = IDX_W + 1;
  localparam int LAST_OUT = ((COLUMNS < MAX_RESULTS) ? COLUMNS : MAX_RESULTS) - 1;

  // level mapping: coord = (pos + 1024) * (ROWS-1) * 256 / 2048, saturated
  localparam int LVL_OFFSET = 1024;
  localparam int LVL_MUL    = (ROWS - 1) * 256;
  localparam int LVL_SHIFT  = 11;
  localparam int PROD_W     = 32;
  localparam int COORD_MAX  = ROWS * 256 - 1;
  localparam int COORD_W    = $clog2(ROWS * 256);
  localparam int BRIGHT_MOD = 255;

  localparam logic signed [15:0] KICK_RESET = -16'sd256;

  localparam logic OP_KICK  = 1'b0;
  localparam logic OP_FRAME = 1'b1;

  typedef enum logic [2:0] {
    DP_NOP,
    DP_KICK,
    DP_START,
    DP_COUPLE,
    DP_MOVE,
    DP_EMIT
  } dp_op_e;

  typedef struct packed {
    dp_op_e           op;
    logic [IDX_W-1:0] idx;
  } wcw_cmd_t;

  typedef struct packed {
    logic out_free;
  } wcw_sts_t;

endpackage

/* rtl/core/wcw_datapath.sv */
// column state registers, coupling and motion arithmetic, level output register
`include "water_column_wave_step_macros.svh"

module wcw_datapath (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  wcw_pkg::wcw_cmd_t      cmd_i,
  output wcw_pkg::wcw_sts_t      sts_o,
  input  logic [3:0]             column_i,
  input  logic                   cfg_we_i,
  input  logic signed [15:0]     cfg_wdata_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [3:0]             out_column_o,
  output logic [3:0]             full_rows_o,
  output logic [7:0]             top_brightness_o,
  output logic                   last_o
);
  import wcw_pkg::*;

  logic signed [15:0] pos_q [COLUMNS];
  logic signed [15:0] vel_q [COLUMNS];
  logic signed [15:0] kick_q;
  logic               out_valid_q;

  logic signed [15:0] prev_q, cur_q;
  logic [PROD_W-1:0]  prod_q, prod_d;

  logic [3:0]         out_column_q;
  logic [3:0]         full_rows_q;
  logic [7:0]         top_q;
  logic               last_q;

  // truncating halve of a signed value
  function automatic logic signed [15:0] half_trunc(input logic signed [15:0] x);
    half_trunc = $signed(x + 16'(x[15])) >>> 1;
  endfunction

  // kick address check
  logic [7:0]       col_ext;
  logic             col_ok;
  logic [IDX_W-1:0] kick_idx;

  assign col_ext  = 8'(column_i);
  assign col_ok   = col_ext < 8'(COLUMNS);
  assign kick_idx = IDX_W'(column_i);

  // coupling: right neighbour read
  logic [IDX1_W-1:0]  idx_p1;
  logic               nxt_ok;
  logic signed [15:0] nxt_pos;
  logic signed [15:0] nsum;
  logic signed [15:0] vel_cpl;

  assign idx_p1  = {1'b0, cmd_i.idx} + IDX1_W'(1);
  assign nxt_ok  = idx_p1 < IDX1_W'(COLUMNS);
  assign nxt_pos = nxt_ok ? pos_q[idx_p1[IDX_W-1:0]] : 16'sd0;
  assign nsum    = prev_q + nxt_pos;
  assign vel_cpl = vel_q[cmd_i.idx] + half_trunc(nsum) - cur_q;

  // motion: damp toward zero, then move
  logic signed [15:0] v_cur, v_damp, pos_new;
  logic signed [16:0] lvl_t;

  assign v_cur   = vel_q[cmd_i.idx];
  assign v_damp  = v_cur[15] ? (v_cur + 16'sd1) :
                   ((v_cur != 16'sd0) ? (v_cur - 16'sd1) : v_cur);
  assign pos_new = pos_q[cmd_i.idx] + half_trunc(v_damp);
  assign lvl_t   = $signed({pos_new[15], pos_new}) + 17'(LVL_OFFSET);

  always_comb begin
    if (lvl_t[16]) begin
      prod_d = '0;
    end else begin
      prod_d = PROD_W'(lvl_t[15:0]) * PROD_W'(LVL_MUL);
    end
  end

  // level: saturate, split into full rows and top brightness
  logic [PROD_W-1:0]  coord_full;
  logic [COORD_W-1:0] coord;
  logic [COORD_W-1:0] coord_hi;
  logic [8:0]         bsum;
  logic [8:0]         bmod;

  assign coord_full = prod_q >> LVL_SHIFT;
  assign coord      = (coord_full > PROD_W'(COORD_MAX)) ? COORD_W'(COORD_MAX)
                                                        : coord_full[COORD_W-1:0];
  assign coord_hi   = coord >> 8;
  assign bsum       = 9'(coord_hi) + 9'(coord[7:0]);

  always_comb begin
    if (bsum >= 9'(2 * BRIGHT_MOD)) begin
      bmod = bsum - 9'(2 * BRIGHT_MOD);
    end else if (bsum >= 9'(BRIGHT_MOD)) begin
      bmod = bsum - 9'(BRIGHT_MOD);
    end else begin
      bmod = bsum;
    end
  end

  // column state, register and output handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < COLUMNS; i++) begin
        pos_q[i] <= '0;
        vel_q[i] <= '0;
      end
      kick_q      <= KICK_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        kick_q <= cfg_wdata_i;
      end
      case (cmd_i.op)
        DP_KICK: begin
          if (col_ok) begin
            vel_q[kick_idx] <= kick_q;
          end
        end
        DP_COUPLE: begin
          vel_q[cmd_i.idx] <= vel_cpl;
        end
        DP_MOVE: begin
          vel_q[cmd_i.idx] <= v_damp;
          pos_q[cmd_i.idx] <= pos_new;
        end
        default: begin
        end
      endcase
      if (cmd_i.op == DP_EMIT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      DP_START: begin
        prev_q <= '0;
        cur_q  <= pos_q[0];
      end
      DP_COUPLE: begin
        prev_q <= cur_q;
        cur_q  <= nxt_pos;
      end
      DP_MOVE: begin
        prod_q <= prod_d;
      end
      DP_EMIT: begin
        out_column_q <= 4'(cmd_i.idx);
        full_rows_q  <= coord_hi[3:0];
        top_q        <= bmod[7:0];
        last_q       <= (32'(cmd_i.idx) == 32'(LAST_OUT));
      end
      default: begin
      end
    endcase
  end

  assign sts_o.out_free  = !out_valid_q || out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign out_column_o    = out_column_q;
  assign full_rows_o     = full_rows_q;
  assign top_brightness_o = top_q;
  assign last_o          = last_q;

  `WCW_ASSERT_NXT(a_emit_sets_valid, clk_i, rst_ni, cmd_i.op == DP_EMIT, out_valid_q, "result not presented after emit")
  `WCW_ASSERT_IMP(a_top_in_range, clk_i, rst_ni, out_valid_q, top_q != 8'(BRIGHT_MOD), "top brightness not reduced")
  `WCW_ASSERT_IMP(a_emit_when_free, clk_i, rst_ni, cmd_i.op == DP_EMIT, !out_valid_q || out_ready_i, "emit over a pending result")

endmodule

/* rtl/core/wcw_ctrl.sv */
// sequencer for kick and frame transactions
`include "water_column_wave_step_macros.svh"

module wcw_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               op_i,
  output logic               in_ready_o,
  input  wcw_pkg::wcw_sts_t  sts_i,
  output wcw_pkg::wcw_cmd_t  cmd_o
);
  import wcw_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_COUPLE = 2'd1;
  localparam logic [1:0] S_MOVE   = 2'd2;
  localparam logic [1:0] S_EMIT   = 2'd3;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(COLUMNS - 1);

  logic [1:0]       state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             idx_out;

  assign in_ready_o = (state_q == S_IDLE);
  assign idx_out    = 32'(idx_q) < 32'(MAX_RESULTS);

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    cmd_o.op  = DP_NOP;
    cmd_o.idx = idx_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (op_i == OP_FRAME) begin
            cmd_o.op = DP_START;
            state_d  = S_COUPLE;
            idx_d    = '0;
          end else begin
            cmd_o.op = DP_KICK;
          end
        end
      end
      S_COUPLE: begin
        cmd_o.op = DP_COUPLE;
        if (idx_q == IDX_LAST) begin
          state_d = S_MOVE;
          idx_d   = '0;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      S_MOVE: begin
        cmd_o.op = DP_MOVE;
        if (idx_out) begin
          state_d = S_EMIT;
        end else if (idx_q == IDX_LAST) begin
          state_d = S_IDLE;
          idx_d   = '0;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.op = DP_EMIT;
          if (idx_q == IDX_LAST) begin
            state_d = S_IDLE;
            idx_d   = '0;
          end else begin
            state_d = S_MOVE;
            idx_d   = idx_q + IDX_W'(1);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
        idx_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  `WCW_ASSERT_NXT(a_frame_start, clk_i, rst_ni, (state_q == S_IDLE) && in_valid_i && (op_i == OP_FRAME), (state_q == S_COUPLE) && (idx_q == '0), "frame did not start coupling pass")
  `WCW_ASSERT_NXT(a_couple_done, clk_i, rst_ni, (state_q == S_COUPLE) && (idx_q == IDX_LAST), (state_q == S_MOVE) && (idx_q == '0), "coupling pass did not hand over to motion pass")
  `WCW_ASSERT_IMP(a_idle_idx, clk_i, rst_ni, state_q == S_IDLE, idx_q == '0, "column counter not cleared between frames")

endmodule

/* rtl/core/water_column_wave_step.sv */
// top level of the water column wave step: controller plus datapath
//
// input channel (in_valid_i / in_ready_o, payload op_i, column_i):
//   op_i = 0 kicks column_i, setting its velocity to the kick strength;
//   a kick out of range is dropped; a kick gives no result
//   op_i = 1 advances one frame and gives one result per column, in column
//   order, with last_o set on the final one
// output channel (out_valid_o / out_ready_i): one registered result
//   transaction per column: out_column_o, full_rows_o, top_brightness_o, last_o
// config: cfg_we_i writes cfg_wdata_i into the kick strength
// frame sequence: the accepting cycle, the coupling pass over every column,
//   then per column a motion update and then its level into the output
//   register; the next column waits while the output register is not free
// a new transaction is taken only once the frame's last result sits in the
//   output register, which then waits for the receiver on its own
// a receiver stall holds the output register and pauses the sweep at the
//   next column; nothing is dropped
// reset clears all positions and velocities to zero, sets the kick strength
//   to -256 and empties the output register
module water_column_wave_step (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input transactions
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               op_i,
  input  logic [3:0]         column_i,
  // result transactions
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [3:0]         out_column_o,
  output logic [3:0]         full_rows_o,
  output logic [7:0]         top_brightness_o,
  output logic               last_o,
  // kick strength register
  input  logic               cfg_we_i,
  input  logic signed [15:0] cfg_wdata_i
);
  import wcw_pkg::*;

  // command from sequencer to datapath, status back
  wcw_cmd_t cmd;
  wcw_sts_t sts;

  // sequencer: idle / coupling sweep / motion sweep / result hand-off
  wcw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .op_i       (op_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // column registers, wave arithmetic and output register
  wcw_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .column_i         (column_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_column_o     (out_column_o),
    .full_rows_o      (full_rows_o),
    .top_brightness_o (top_brightness_o),
    .last_o           (last_o)
  );

endmodule

/* sim/water_column_wave_step_tb.sv */
// self-checking testbench of the water column wave step: directed and random kick/frame traffic
`timescale 1ns / 1ps

module water_column_wave_step_tb;
  import wcw_pkg::*;

  localparam int HALF_PERIOD_NS = 5;
  localparam int RESET_CYCLES   = 7;
  localparam int SETTLE_CYCLES  = 8;
  localparam int TAIL_CYCLES    = 3 * COLUMNS + 16;
  localparam int TIMEOUT_NS     = 3_000_000;
  localparam int FRAME_RESULTS  = (COLUMNS < MAX_RESULTS) ? COLUMNS : MAX_RESULTS;
  localparam int COORD_TOP      = ROWS * 256 - 1;

  typedef struct {
    logic [3:0] col;
    logic [3:0] rows;
    logic [7:0] bright;
    logic       last;
  } level_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  logic               op_i        = OP_KICK;
  logic [3:0]         column_i    = 4'd0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [3:0]         out_column_o;
  logic [3:0]         full_rows_o;
  logic [7:0]         top_brightness_o;
  logic               last_o;
  logic               cfg_we_i    = 1'b0;
  logic signed [15:0] cfg_wdata_i = '0;

  // surface model kept alongside the block
  logic signed [15:0] wave_pos [COLUMNS];
  logic signed [15:0] wave_vel [COLUMNS];
  logic signed [15:0] kick_level;
  level_t             expected_levels [$];

  int mismatch_count = 0;
  int tx_idle_pct    = 0;
  int rx_stall_pct   = 0;

  water_column_wave_step u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .op_i            (op_i),
    .column_i        (column_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_column_o    (out_column_o),
    .full_rows_o     (full_rows_o),
    .top_brightness_o(top_brightness_o),
    .last_o          (last_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  always #(HALF_PERIOD_NS) clk_i = ~clk_i;

  initial begin
    #(TIMEOUT_NS);
    $display("[water_column_wave_step] ERROR");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // one frame: coupling on old positions, then damping and motion, then levels
  task automatic advance_surface();
    logic signed [15:0] nsum;
    int                 half, v, p;
    longint             coord;
    level_t             lvl;
    for (int i = 0; i < COLUMNS; i++) begin
      nsum = '0;
      if (i > 0) nsum = nsum + wave_pos[i-1];
      if (i < COLUMNS - 1) nsum = nsum + wave_pos[i+1];
      half = int'(nsum) / 2;
      v = int'(wave_vel[i]) + half - int'(wave_pos[i]);
      wave_vel[i] = 16'(v);
    end
    for (int i = 0; i < COLUMNS; i++) begin
      v = int'(wave_vel[i]);
      if (v < 0) v = v + 1;
      else if (v > 0) v = v - 1;
      wave_vel[i] = 16'(v);
      p = int'(wave_pos[i]) + v / 2;
      wave_pos[i] = 16'(p);
      if (i < FRAME_RESULTS) begin
        coord = (longint'(wave_pos[i]) + 1024) * longint'((ROWS - 1) * 256) / 2048;
        if (coord < 0) coord = 0;
        if (coord > COORD_TOP) coord = COORD_TOP;
        lvl.col    = 4'(i);
        lvl.rows   = 4'(coord >> 8);
        lvl.bright = 8'(coord % 255);
        lvl.last   = (i == FRAME_RESULTS - 1);
        expected_levels.push_back(lvl);
      end
    end
  endtask

  // one input transaction, with optional idle cycles in front
  task automatic send_item(input logic op, input logic [3:0] col);
    while ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    op_i       <= op;
    column_i   <= col;
    do @(posedge clk_i); while (!in_ready_o);
    if (op == OP_KICK) begin
      if (int'(col) < COLUMNS) wave_vel[col] = kick_level;
    end else begin
      advance_surface();
    end
  endtask

  task automatic hold_input();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic wait_levels_drained();
    while (expected_levels.size() != 0) @(posedge clk_i);
  endtask

  // register writes only with the block idle
  task automatic write_kick_strength(input logic signed [15:0] val);
    hold_input();
    wait_levels_drained();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    kick_level = val;
  endtask

  // receiver side: random stalls at the chosen rate
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= rx_stall_pct);
  end

  // result checker
  always @(posedge clk_i) begin
    level_t exp_lvl;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_levels.size() == 0) begin
        report_mismatch($sformatf("unexpected result column %0d", out_column_o));
      end else begin
        exp_lvl = expected_levels.pop_front();
        if (out_column_o !== exp_lvl.col)
          report_mismatch($sformatf("out_column %0d, want %0d", out_column_o, exp_lvl.col));
        if (full_rows_o !== exp_lvl.rows)
          report_mismatch($sformatf("col %0d full_rows %0d, want %0d",
                                    exp_lvl.col, full_rows_o, exp_lvl.rows));
        if (top_brightness_o !== exp_lvl.bright)
          report_mismatch($sformatf("col %0d top_brightness %0d, want %0d",
                                    exp_lvl.col, top_brightness_o, exp_lvl.bright));
        if (last_o !== exp_lvl.last)
          report_mismatch($sformatf("col %0d last %0b, want %0b",
                                    exp_lvl.col, last_o, exp_lvl.last));
      end
    end
  end

  task automatic test_reset_frame();
    send_item(OP_FRAME, 4'd0);
  endtask

  // kicks at both edge columns, default strength
  task automatic test_edge_kicks();
    send_item(OP_KICK, 4'd0);
    send_item(OP_KICK, 4'd15);
    send_item(OP_FRAME, 4'd9);
    send_item(OP_FRAME, 4'd15);
  endtask

  task automatic test_strength_extremes();
    write_kick_strength(16'sd32767);
    send_item(OP_KICK, 4'd7);
    send_item(OP_FRAME, 4'd0);
    write_kick_strength(-16'sd32768);
    send_item(OP_KICK, 4'd8);
    send_item(OP_FRAME, 4'd0);
    send_item(OP_FRAME, 4'd0);
    write_kick_strength(16'sd0);
    send_item(OP_KICK, 4'd7);
    send_item(OP_FRAME, 4'd0);
  endtask

  // drive levels into both saturation limits
  task automatic test_level_saturation();
    write_kick_strength(16'sd32767);
    send_item(OP_KICK, 4'd3);
    send_item(OP_KICK, 4'd4);
    send_item(OP_FRAME, 4'd0);
    send_item(OP_FRAME, 4'd0);
    write_kick_strength(-16'sd32768);
    send_item(OP_KICK, 4'd10);
    send_item(OP_KICK, 4'd11);
    send_item(OP_FRAME, 4'd0);
    send_item(OP_FRAME, 4'd0);
  endtask

  // sender holds off until every level of the earlier frames is back
  task automatic test_pause_until_drained();
    send_item(OP_FRAME, 4'd0);
    send_item(OP_FRAME, 4'd0);
    hold_input();
    wait_levels_drained();
    send_item(OP_FRAME, 4'd0);
  endtask

  // random kicks and frames in blocks, new kick strength between blocks
  task automatic test_random_traffic(input int n_items, input int tx_pct, input int rx_pct);
    logic signed [15:0] strength;
    int                 pick;
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    for (int n = 0; n < n_items; n++) begin
      if (n % 20 == 0) begin
        pick = $urandom_range(7);
        case (pick)
          0: strength = 16'sd32767;
          1: strength = -16'sd32768;
          2: strength = 16'sd0;
          3: strength = KICK_RESET;
          default: strength = 16'($urandom);
        endcase
        write_kick_strength(strength);
      end
      if ($urandom_range(99) < 40) send_item(OP_FRAME, 4'($urandom));
      else send_item(OP_KICK, 4'($urandom));
    end
  endtask

  initial begin
    for (int i = 0; i < COLUMNS; i++) begin
      wave_pos[i] = '0;
      wave_vel[i] = '0;
    end
    kick_level = KICK_RESET;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_frame();
    test_edge_kicks();
    test_strength_extremes();
    test_level_saturation();
    test_pause_until_drained();
    test_random_traffic(80, 0, 0);
    test_random_traffic(80, 60, 0);
    test_random_traffic(80, 0, 60);
    test_random_traffic(80, 20, 20);

    hold_input();
    wait_levels_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (expected_levels.size() != 0)
      report_mismatch($sformatf("%0d expected levels never arrived", expected_levels.size()));
    if (mismatch_count == 0) begin
      $display("[water_column_wave_step] OK");
    end else begin
      $display("[water_column_wave_step] ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/wcw_pkg.sv
rtl/core/wcw_datapath.sv
rtl/core/wcw_ctrl.sv
rtl/core/water_column_wave_step.sv
sim/water_column_wave_step_tb.sv
